### rtl/rvx_pkg.sv
`default_nettype none
package rvx_pkg;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
        logic [31:0] pc;
    } in_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [31:0] write_value;
        logic [31:0] next_pc;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size;
        logic        load_unsigned;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        invalid;
    } out_item_t;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MUL  = 7'h01;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Operation class chosen by the front end.
    typedef enum logic [2:0] {
        CLS_BAD,
        CLS_SIMPLE,
        CLS_ALU,
        CLS_MUL,
        CLS_DIV
    } op_class_t;

    // Decoded item handed from the front end to the back end.
    typedef struct packed {
        op_class_t   cls;
        logic [2:0]  f3;
        logic        alt;
        logic [31:0] opa;
        logic [31:0] opb;
        logic        we;
        logic [4:0]  dest;
        logic [31:0] val;
        logic [31:0] npc;
        logic [1:0]  kind;
        logic [1:0]  size;
        logic        uns;
        logic [31:0] addr;
        logic [31:0] sdata;
    } dec_item_t;

    localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

### rtl/rv32im_execute_unit.sv
`default_nettype none
// An input beat passes the input queue, operand stage, 32 divide stages,
// result buffer write and output register before its result is offered.
// Throughput: one beat per cycle unless the output stalls; the 32-stage
// radix-2 divider pipeline and the multiplier stage set depth, not rate.
// Reset: aresetn, synchronous, active low, empties queue and pipeline.
module rv32im_execute_unit (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  var rvx_pkg::in_item_t s_item,
    output logic                  m_valid,
    input  wire                   m_ready,
    output rvx_pkg::out_item_t    m_item
);
    import rvx_pkg::*;

    dec_item_t dec, q_data;
    logic      q_valid, q_ready;

    rvx_front u_front (
        .item (s_item),
        .dec  (dec)
    );

    rvx_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (dec),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    rvx_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (q_valid),
        .s_ready (q_ready),
        .s_item  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire

### rtl/rvx_front.sv
`default_nettype none
module rvx_front (
    input  var rvx_pkg::in_item_t  item,
    output var rvx_pkg::dec_item_t dec
);
    import rvx_pkg::*;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi, imms, immb, immj, immu, pc4, a, b;
    logic        lts, ltu, take, bad, hasrd;

    // Field and immediate extraction.
    always_comb begin
        opc  = item.instruction[6:0];
        rd   = item.instruction[11:7];
        f3   = item.instruction[14:12];
        f7   = item.instruction[31:25];
        a    = item.rs1_value;
        b    = item.rs2_value;
        immi = {{20{item.instruction[31]}}, item.instruction[31:20]};
        imms = {{20{item.instruction[31]}}, item.instruction[31:25], item.instruction[11:7]};
        immb = {{20{item.instruction[31]}}, item.instruction[7], item.instruction[30:25],
                item.instruction[11:8], 1'b0};
        immj = {{12{item.instruction[31]}}, item.instruction[19:12], item.instruction[20],
                item.instruction[30:21], 1'b0};
        immu = {item.instruction[31:12], 12'h000};
        pc4  = item.pc + 32'd4;
        ltu  = a < b;
        lts  = $signed(a) < $signed(b);
    end

    // Decode, branches, jumps and address generation.
    always_comb begin
        dec       = '0;
        dec.cls   = CLS_SIMPLE;
        dec.f3    = f3;
        dec.opa   = a;
        dec.opb   = b;
        dec.npc   = pc4;
        bad       = 1'b0;
        hasrd     = 1'b1;
        take      = 1'b0;
        case (opc)
            OPC_LUI: begin
                dec.val = immu;
            end
            OPC_AUIPC: begin
                dec.val = item.pc + immu;
            end
            OPC_JAL: begin
                dec.val = pc4;
                dec.npc = item.pc + immj;
            end
            OPC_JALR: begin
                if (f3 != 3'd0) begin
                    bad = 1'b1;
                end else begin
                    dec.val = pc4;
                    dec.npc = (a + immi) & ~32'd1;
                end
            end
            OPC_BRANCH: begin
                hasrd = 1'b0;
                case (f3)
                    3'd0:    take = a == b;
                    3'd1:    take = a != b;
                    3'd4:    take = lts;
                    3'd5:    take = !lts;
                    3'd6:    take = ltu;
                    3'd7:    take = !ltu;
                    default: bad = 1'b1;
                endcase
                if (take) begin
                    dec.npc = item.pc + immb;
                end
            end
            OPC_LOAD: begin
                if (f3 == 3'd3 || f3 > 3'd5) begin
                    bad = 1'b1;
                end else begin
                    dec.kind = MEM_LOAD;
                    dec.size = f3[1:0];
                    dec.uns  = f3[2];
                    dec.addr = a + immi;
                end
            end
            OPC_STORE: begin
                hasrd = 1'b0;
                if (f3 > 3'd2) begin
                    bad = 1'b1;
                end else begin
                    dec.kind  = MEM_STORE;
                    dec.size  = f3[1:0];
                    dec.sdata = b;
                    dec.addr  = a + imms;
                end
            end
            OPC_OPIMM: begin
                if (f3 == 3'd1 && f7 != F7_BASE) begin
                    bad = 1'b1;
                end else if (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT) begin
                    bad = 1'b1;
                end else begin
                    dec.cls = CLS_ALU;
                    dec.alt = (f3 == 3'd5) && (f7 == F7_ALT);
                    dec.opb = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, immi[4:0]} : immi;
                end
            end
            OPC_OP: begin
                if (f7 == F7_MUL) begin
                    dec.cls = f3[2] ? CLS_DIV : CLS_MUL;
                end else if (f7 == F7_BASE) begin
                    dec.cls = CLS_ALU;
                end else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
                    dec.cls = CLS_ALU;
                    dec.alt = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase

        if (bad) begin
            dec      = '0;
            dec.cls  = CLS_BAD;
            dec.npc  = item.pc;
        end else if (hasrd) begin
            dec.dest = rd;
            dec.we   = rd != 5'd0;
            if (dec.kind == MEM_LOAD || rd == 5'd0) begin
                dec.val = '0;
                dec.cls = CLS_SIMPLE;
            end
        end else begin
            dec.cls = CLS_SIMPLE;
        end
    end

endmodule
`default_nettype wire

### rtl/rvx_queue.sv
`default_nettype none
module rvx_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     wr_valid,
    output logic                    wr_ready,
    input  var rvx_pkg::dec_item_t  wr_data,
    output logic                    rd_valid,
    input  wire                     rd_ready,
    output rvx_pkg::dec_item_t      rd_data
);
    import rvx_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    dec_item_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg, rptr_reg;
    logic [PW:0]       count_reg, count_next;
    logic              wr_fire, rd_fire;

    assign wr_ready = count_reg != PW'(0) + (PW+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // Occupancy tracking.
    always_comb begin
        count_next = count_reg;
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_fire) begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd_fire) begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue overfilled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> !rd_valid)
        else $error("read valid while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_fire && !rd_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not rise on write");

endmodule
`default_nettype wire

### rtl/rvx_back.sv
`default_nettype none
module rvx_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  var rvx_pkg::dec_item_t  s_item,
    output logic                    m_valid,
    input  wire                     m_ready,
    output rvx_pkg::out_item_t      m_item
);
    import rvx_pkg::*;

    // Divide pipeline depth: one quotient bit per stage.
    localparam int NST  = 32;
    localparam int TAGS = NST + 1;
    // Result buffer depth; also the credit limit for items in flight.
    // It covers the round trip, so the input waits on it only if the output stalls.
    localparam int RQD  = NST + 4;

    typedef struct packed {
        logic        valid;
        dec_item_t   d;
    } tag_t;

    // Divider stage payload.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] den;
        logic        negq;
        logic        negr;
        logic        zero;
    } dv_t;

    tag_t        tag_reg [TAGS];
    dv_t         dv_reg  [NST+1];
    logic [63:0] prod_reg;
    logic        adv;

    // Output holding register.
    out_item_t   obuf_reg;
    logic        ovalid_reg;
    logic [5:0]  inflight_reg, inflight_next;
    logic        in_fire, out_fire, fin;

    // Credits: accept only while all items in flight fit into the output buffers.
    assign s_ready  = inflight_reg < 6'(RQD);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = ovalid_reg;
    assign m_item   = obuf_reg;
    assign out_fire = m_valid && m_ready;
    assign adv      = 1'b1;

    // Final operand stage helpers.
    logic [31:0] a0, b0, ma, mb, alu_v, sh_v;
    logic        na, nb;
    dec_item_t   d0, d0v;
    always_comb begin
        d0 = s_item;
        a0 = d0.opa;
        b0 = d0.opb;
        na = a0[31];
        nb = b0[31];
        ma = na ? 32'd0 - a0 : a0;
        mb = nb ? 32'd0 - b0 : b0;
        sh_v = d0.alt ? 32'($signed(a0) >>> b0[4:0]) : a0 >> b0[4:0];
        case (d0.f3)
            3'd0:    alu_v = d0.alt ? a0 - b0 : a0 + b0;
            3'd1:    alu_v = a0 << b0[4:0];
            3'd2:    alu_v = {31'd0, $signed(a0) < $signed(b0)};
            3'd3:    alu_v = {31'd0, a0 < b0};
            3'd4:    alu_v = a0 ^ b0;
            3'd5:    alu_v = sh_v;
            3'd6:    alu_v = a0 | b0;
            default: alu_v = a0 & b0;
        endcase
        d0v = d0;
        if (d0.cls == CLS_ALU) begin
            d0v.val = alu_v;
        end
    end

    // Stage 0: ALU, multiplier inputs, divider setup.
    logic [32:0] mxa, mxb;
    always_comb begin
        mxa = {d0.f3[1:0] != 2'd3 && d0.f3[1:0] != 2'd0 && na, a0};
        mxb = {d0.f3[1:0] == 2'd1 && nb, b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0].valid <= 1'b0;
        end else if (adv) begin
            tag_reg[0].valid <= in_fire;
        end
        if (adv) begin
            tag_reg[0].d <= d0v;
            prod_reg <= 64'($signed(mxa) * $signed(mxb));
            dv_reg[0].rem  <= '0;
            dv_reg[0].quo  <= d0.f3[0] ? a0 : ma;
            dv_reg[0].den  <= d0.f3[0] ? b0 : mb;
            dv_reg[0].negq <= !d0.f3[0] && (na != nb);
            dv_reg[0].negr <= !d0.f3[0] && na;
            dv_reg[0].zero <= b0 == 32'd0;
        end
    end

    // Restoring divider, one bit per stage.
    for (genvar i = 0; i < NST; i++) begin : g_div
        logic [32:0] trial;
        dv_t         nxt;
        always_comb begin
            trial = {dv_reg[i].rem, dv_reg[i].quo[31]} - {1'b0, dv_reg[i].den};
            nxt   = dv_reg[i];
            if (!trial[32]) begin
                nxt.rem = trial[31:0];
                nxt.quo = {dv_reg[i].quo[30:0], 1'b1};
            end else begin
                nxt.rem = {dv_reg[i].rem[30:0], dv_reg[i].quo[31]};
                nxt.quo = {dv_reg[i].quo[30:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[i+1] <= nxt;
            end
        end
    end

    // Multiplier result rides the tag line until the end.
    logic [31:0] mul_v;
    dec_item_t   d1v;
    always_comb begin
        mul_v = (tag_reg[0].d.f3[1:0] == 2'd0) ? prod_reg[31:0] : prod_reg[63:32];
        d1v   = tag_reg[0].d;
        if (tag_reg[0].d.cls == CLS_MUL) begin
            d1v.val = mul_v;
        end
    end

    for (genvar i = 1; i < TAGS; i++) begin : g_tag
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i].valid <= 1'b0;
            end else if (adv) begin
                tag_reg[i].valid <= tag_reg[i-1].valid;
            end
            if (adv) begin
                tag_reg[i].d <= (i == 1) ? d1v : tag_reg[i-1].d;
            end
        end
    end

    // Divider result fixup in last stage.
    dv_t         dl;
    logic [31:0] div_v;
    always_comb begin
        dl = dv_reg[NST];
        if (tag_reg[NST].d.f3[1]) begin
            div_v = dl.zero ? tag_reg[NST].d.opa : (dl.negr ? 32'd0 - dl.rem : dl.rem);
        end else begin
            div_v = dl.zero ? 32'hFFFF_FFFF : (dl.negq ? 32'd0 - dl.quo : dl.quo);
        end
    end

    // Assemble result item.
    out_item_t res;
    dec_item_t dz;
    always_comb begin
        dz = tag_reg[NST].d;
        res.write_enable  = dz.we;
        res.dest_index    = dz.dest;
        res.write_value   = (dz.cls == CLS_DIV) ? div_v : dz.val;
        res.next_pc       = dz.npc;
        res.mem_kind      = dz.kind;
        res.mem_size      = dz.size;
        res.load_unsigned = dz.uns;
        res.mem_address   = dz.addr;
        res.store_data    = dz.sdata;
        res.invalid       = dz.cls == CLS_BAD;
        fin               = tag_reg[NST].valid;
    end

    // Result FIFO of depth RQD feeding the output.
    out_item_t rq_reg [RQD];
    logic [5:0] rw_reg, rr_reg;
    always_ff @(posedge aclk) begin
        if (fin) begin
            rq_reg[rw_reg] <= res;
        end
    end

    always_comb begin
        inflight_next = inflight_reg + {5'd0, in_fire} - {5'd0, out_fire};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            rw_reg       <= '0;
            rr_reg       <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            inflight_reg <= inflight_next;
            if (fin) begin
                rw_reg <= (rw_reg == 6'(RQD - 1)) ? '0 : rw_reg + 1'b1;
            end
            if (!ovalid_reg || out_fire) begin
                if (rw_reg != rr_reg) begin
                    ovalid_reg <= 1'b1;
                    rr_reg     <= (rr_reg == 6'(RQD - 1)) ? '0 : rr_reg + 1'b1;
                end else begin
                    ovalid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!ovalid_reg || out_fire) begin
            obuf_reg <= rq_reg[rr_reg];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 6'(RQD))
        else $error("too many items in flight");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg == '0) |-> !m_valid)
        else $error("result with nothing in flight");

endmodule
`default_nettype wire
